// ===== rtl/tmbi_pkg.sv =====
// Shared types and constants for the triangle mesh barycentric interpolator.
// Used by the top level and its checker; no dependencies.
package tmbi_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned TOL_W   = 20;
  localparam int unsigned ROW_W   = 4 * COORD_W;  // {im, re, y, x}
  localparam int unsigned AREA_W  = 67;           // exact doubled area

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_IMAG_ENABLE = 1'b0;
  localparam logic REG_EDGE_TOL    = 1'b1;

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

endpackage

// ===== rtl/tmbi_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module tmbi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/triangle_mesh_barycentric_interp.sv =====
// Load beats and clears are taken in the idle state; the third corner of a triangle also
// passes through S_AMUL and S_AWR. A query scans triangles one at a time through the single
// read port of each memory, at one shared address: a triangle is rejected by its bounding box
// or zero area, or reaches the shared iterative divider (31 steps per weight) and either fails
// the weight check or matches, which ends the scan; the result is then issued from S_OUT.
// Reset clears the triangle count, corner phase and handshakes; memories need no clearing.
// Depends on tmbi_pkg and tmbi_ram.
module triangle_mesh_barycentric_interp #(
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_x, vertex_y, value_re, value_im, point_x, point_y (32 bits each)
  input  logic [191:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_re, out_im (32 bits each)
  output logic [63:0]  m_axis_tdata,
  // found
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned CW = $clog2(MAX_TRIANGLES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TRIANGLES);
  localparam logic [tmbi_pkg::TOL_W-1:0] TOL_W_ONE = tmbi_pkg::TOL_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_AMUL, S_AWR, S_RD, S_BOX, S_NMUL, S_NSUM,
    S_DSTART, S_DIV, S_WCHK, S_VMUL, S_VSUM, S_OUT
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q, tri_q;
  logic [1:0]    phase_q;
  logic          imag_q;
  logic [tmbi_pkg::TOL_W-1:0] tol_q;

  logic signed [31:0] c0x_q, c0y_q, c1x_q, c1y_q, c2x_q, c2y_q, px_q, py_q;
  logic          last_q;
  logic signed [65:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [66:0] numa_q, numb_q;
  logic [66:0]   den_q;
  logic [66:0]   rem_q;
  logic [30:0]   quo_q;
  logic [4:0]    step_q;
  logic          lsb_q, over_q, neg_q, wsel_q, vim_q;
  logic signed [31:0] wa_q, wb_q;
  logic signed [33:0] wc_q;
  logic          res_found_q;
  logic signed [31:0] res_re_q, res_im_q;

  logic          m_valid_q, m_found_q, m_last_q;
  logic [63:0]   m_data_q;

  // input fields
  logic signed [31:0] in_vx, in_vy, in_pre, in_pim, in_px, in_py;
  assign in_vx  = s_axis_tdata[31:0];
  assign in_vy  = s_axis_tdata[63:32];
  assign in_pre = s_axis_tdata[95:64];
  assign in_pim = s_axis_tdata[127:96];
  assign in_px  = s_axis_tdata[159:128];
  assign in_py  = s_axis_tdata[191:160];

  logic s_acc, load_we;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign load_we = s_acc && (s_axis_tuser == tmbi_pkg::OP_LOAD) && (cnt_q < MaxCnt);

  // corner banks: one per corner slot, one row per triangle
  logic [tmbi_pkg::ROW_W-1:0] row [3];
  logic rd_en;
  assign rd_en = (state_q == S_RD);

  for (genvar k = 0; k < 3; k++) begin : g_bank
    tmbi_ram #(.Width(tmbi_pkg::ROW_W), .Depth(MAX_TRIANGLES)) u_bank (
      .clk_i   (clk_i),
      .we_i    (load_we && (phase_q == 2'(k))),
      .waddr_i (cnt_q[AW-1:0]),
      .wdata_i ({in_pim, in_pre, in_vy, in_vx}),
      .re_i    (rd_en),
      .raddr_i (tri_q[AW-1:0]),
      .rdata_o (row[k])
    );
  end

  logic signed [66:0] area_wdata, area_rd;
  assign area_wdata = 67'(p0_q) + 67'(p1_q);

  tmbi_ram #(.Width(tmbi_pkg::AREA_W), .Depth(MAX_TRIANGLES)) u_area (
    .clk_i   (clk_i),
    .we_i    (state_q == S_AWR),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (area_wdata),
    .re_i    (rd_en),
    .raddr_i (tri_q[AW-1:0]),
    .rdata_o (area_rd)
  );

  logic signed [31:0] x0, y0, x1, y1, x2, y2, v0, v1, v2;
  assign x0 = row[0][31:0];
  assign y0 = row[0][63:32];
  assign x1 = row[1][31:0];
  assign y1 = row[1][63:32];
  assign x2 = row[2][31:0];
  assign y2 = row[2][63:32];
  assign v0 = vim_q ? row[0][127:96] : row[0][95:64];
  assign v1 = vim_q ? row[1][127:96] : row[1][95:64];
  assign v2 = vim_q ? row[2][127:96] : row[2][95:64];

  // bounding box and zero area
  logic box_out, area_zero;
  assign box_out = (px_q > x0 && px_q > x1 && px_q > x2) ||
                   (px_q < x0 && px_q < x1 && px_q < x2) ||
                   (py_q > y0 && py_q > y1 && py_q > y2) ||
                   (py_q < y0 && py_q < y1 && py_q < y2);
  assign area_zero = (area_rd == '0);

  // differences, 33 bits
  logic signed [32:0] da_y12, da_x02, da_x21, da_y02;
  logic signed [32:0] dn_y12, dn_x21, dn_y20, dn_x02, dn_px, dn_py;
  assign da_y12 = 33'(c1y_q) - 33'(c2y_q);
  assign da_x02 = 33'(c0x_q) - 33'(c2x_q);
  assign da_x21 = 33'(c2x_q) - 33'(c1x_q);
  assign da_y02 = 33'(c0y_q) - 33'(c2y_q);
  assign dn_y12 = 33'(y1) - 33'(y2);
  assign dn_x21 = 33'(x2) - 33'(x1);
  assign dn_y20 = 33'(y2) - 33'(y0);
  assign dn_x02 = 33'(x0) - 33'(x2);
  assign dn_px  = 33'(px_q) - 33'(x2);
  assign dn_py  = 33'(py_q) - 33'(y2);

  // divider setup
  logic signed [66:0] num_sel;
  logic [66:0] num_mag, den_mag;
  assign num_sel = wsel_q ? numb_q : numa_q;
  assign num_mag = num_sel[66] ? 67'(-num_sel) : 67'(num_sel);
  assign den_mag = area_rd[66] ? 67'(-area_rd) : 67'(area_rd);

  logic [67:0] cand;
  logic        take;
  assign cand = {rem_q, lsb_q && (step_q == 5'd30)};
  assign take = (cand >= {1'b0, den_q});

  logic [30:0] quo_next;
  logic [31:0] mag;
  logic signed [31:0] weight;
  assign quo_next = {quo_q[29:0], take};
  assign mag      = over_q ? 32'h8000_0000 : {1'b0, quo_next};
  always_comb begin
    if (neg_q) begin
      weight = 32'(-$signed({1'b0, mag}));
    end else if (mag[31]) begin
      weight = 32'h7FFF_FFFF;
    end else begin
      weight = $signed(mag);
    end
  end

  // weight check
  logic signed [33:0] wc_calc, neg_tol;
  logic w_ok;
  assign wc_calc = tmbi_pkg::ONE_Q30 - 34'(wa_q) - 34'(wb_q);
  assign neg_tol = -$signed({14'd0, tol_q});
  always_comb begin
    w_ok = (34'(wa_q) >= neg_tol) && (34'(wb_q) >= neg_tol) && (wc_calc >= neg_tol);
  end

  // value sum, round half up, saturate
  logic signed [67:0] vsum, vrnd;
  logic signed [37:0] vflr;
  logic signed [31:0] vsat;
  assign vsum = 68'(p0_q) + 68'(p1_q) + 68'(p2_q);
  assign vrnd = vsum + 68'sd536870912;
  assign vflr = vrnd[67:30];
  always_comb begin
    if (vflr > 38'sd2147483647) begin
      vsat = 32'sh7FFF_FFFF;
    end else if (vflr < -38'sd2147483648) begin
      vsat = 32'sh8000_0000;
    end else begin
      vsat = vflr[31:0];
    end
  end

  logic last_tri;
  assign last_tri = (tri_q + CW'(1) == cnt_q);

  // result register takes a new beat when empty or being drained
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= '0;
      tri_q       <= '0;
      imag_q      <= 1'b0;
      tol_q       <= TOL_W_ONE;
      m_valid_q   <= 1'b0;
      wsel_q      <= 1'b0;
      vim_q       <= 1'b0;
      res_found_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tmbi_pkg::REG_IMAG_ENABLE: imag_q <= cfg_data_i[0];
          tmbi_pkg::REG_EDGE_TOL:    tol_q  <= cfg_data_i[tmbi_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            case (s_axis_tuser)
              tmbi_pkg::OP_LOAD: begin
                if (load_we) begin
                  case (phase_q)
                    2'd0: begin
                      c0x_q <= in_vx;
                      c0y_q <= in_vy;
                      phase_q <= 2'd1;
                    end
                    2'd1: begin
                      c1x_q <= in_vx;
                      c1y_q <= in_vy;
                      phase_q <= 2'd2;
                    end
                    default: begin
                      c2x_q <= in_vx;
                      c2y_q <= in_vy;
                      state_q <= S_AMUL;
                    end
                  endcase
                end
              end
              tmbi_pkg::OP_QUERY: begin
                px_q        <= in_px;
                py_q        <= in_py;
                last_q      <= s_axis_tlast;
                tri_q       <= '0;
                res_found_q <= 1'b0;
                res_re_q    <= '0;
                res_im_q    <= '0;
                state_q     <= (cnt_q == '0) ? S_OUT : S_RD;
              end
              tmbi_pkg::OP_CLEAR: begin
                cnt_q   <= '0;
                phase_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_AMUL: begin
          p0_q    <= da_y12 * da_x02;
          p1_q    <= da_x21 * da_y02;
          state_q <= S_AWR;
        end
        S_AWR: begin
          cnt_q   <= cnt_q + CW'(1);
          phase_q <= '0;
          state_q <= S_IDLE;
        end
        S_RD: begin
          state_q <= S_BOX;
        end
        S_BOX: begin
          if (box_out || area_zero) begin
            if (last_tri) begin
              state_q <= S_OUT;
            end else begin
              tri_q   <= tri_q + CW'(1);
              state_q <= S_RD;
            end
          end else begin
            state_q <= S_NMUL;
          end
        end
        S_NMUL: begin
          p0_q    <= dn_y12 * dn_px;
          p1_q    <= dn_x21 * dn_py;
          p2_q    <= dn_y20 * dn_px;
          p3_q    <= dn_x02 * dn_py;
          state_q <= S_NSUM;
        end
        S_NSUM: begin
          numa_q  <= 67'(p0_q) + 67'(p1_q);
          numb_q  <= 67'(p2_q) + 67'(p3_q);
          wsel_q  <= 1'b0;
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          den_q   <= den_mag;
          over_q  <= ({1'b0, num_mag} >= {den_mag, 1'b0});
          neg_q   <= num_sel[66] ^ area_rd[66];
          rem_q   <= {1'b0, num_mag[66:1]};
          lsb_q   <= num_mag[0];
          quo_q   <= '0;
          step_q  <= 5'd30;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= take ? 67'(cand - {1'b0, den_q}) : cand[66:0];
          quo_q  <= quo_next;
          step_q <= step_q - 5'd1;
          if (step_q == 5'd0) begin
            if (!wsel_q) begin
              wa_q    <= weight;
              wsel_q  <= 1'b1;
              state_q <= S_DSTART;
            end else begin
              wb_q    <= weight;
              state_q <= S_WCHK;
            end
          end
        end
        S_WCHK: begin
          wc_q <= wc_calc;
          if (w_ok) begin
            vim_q   <= 1'b0;
            state_q <= S_VMUL;
          end else if (last_tri) begin
            state_q <= S_OUT;
          end else begin
            tri_q   <= tri_q + CW'(1);
            state_q <= S_RD;
          end
        end
        S_VMUL: begin
          p0_q    <= 66'(wa_q * v0);
          p1_q    <= 66'(wb_q * v1);
          p2_q    <= 66'(wc_q * v2);
          state_q <= S_VSUM;
        end
        S_VSUM: begin
          res_found_q <= 1'b1;
          if (!vim_q) begin
            res_re_q <= vsat;
            if (imag_q) begin
              vim_q   <= 1'b1;
              state_q <= S_VMUL;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            res_im_q <= vsat;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_found_q <= res_found_q;
            m_last_q  <= last_q;
            m_data_q  <= {res_im_q, res_re_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/tmbi_checker.sv =====
// Port-level checker for triangle_mesh_barycentric_interp, bound to the top level.
// Depends on tmbi_pkg.
module tmbi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic         cfg_index_i,
  input logic [31:0]  cfg_data_i
);

  // a beat not taken stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // a miss reports zero values
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("miss with nonzero data");

  // the block is busy in the cycle after it takes a query
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == tmbi_pkg::OP_QUERY
    |=> !s_axis_tready)
    else $error("input taken right after a query");

  // a clear leaves the block ready in the cycle after it
  a_clear_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == tmbi_pkg::OP_CLEAR
    |=> s_axis_tready)
    else $error("block busy after clear");

endmodule

bind triangle_mesh_barycentric_interp tmbi_checker u_tmbi_checker (.*);
